>>> sv/sha256_message_digest_defines.svh
// Assertion macros shared by the digest block.
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SHA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256 check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256 check failed");

`endif

>>> sv/sha256_pkg.sv
// Types, constants and round tables for the SHA-256 digest block.
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] vars_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
  } msg_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        final_word;
  } dig_t;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] WORD_LAST = 2'd3;

  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

>>> sv/sha256_round.sv
// One SHA-256 compression round and the matching message schedule step.
module sha256_round (
  input  sha256_pkg::vars_t vars,
  input  sha256_pkg::word_t k,
  input  sha256_pkg::word_t w0,
  input  sha256_pkg::word_t w1,
  input  sha256_pkg::word_t w9,
  input  sha256_pkg::word_t w14,
  output sha256_pkg::vars_t vars_next,
  output sha256_pkg::word_t w_next
);

  function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  sha256_pkg::word_t big_s0;
  sha256_pkg::word_t big_s1;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;
  sha256_pkg::word_t sm0;
  sha256_pkg::word_t sm1;

  always_comb begin
    big_s1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    big_s0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    ch     = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    maj    = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1     = vars[7] + big_s1 + ch + k + w0;
    t2     = big_s0 + maj;

    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + t2;

    sm0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    sm1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_next = w0 + sm0 + w9 + sm1;
  end

endmodule

>>> sv/sha256_message_digest.sv
// SHA-256 digest over a byte stream: byte packing, padding, round sequencer, output.
//
// Bytes enter one per transaction and shift into a 512-bit block line. The 64th
// byte of a block starts compression: 64 rounds through one shared round unit,
// then an update step that folds the result into the hash, and the input stays
// stalled until that update is done. On a last transaction the sequencer feeds
// the 0x80 marker, zeros and the 64-bit bit length one byte per cycle outside
// compression (one extra block when the marker lands in the last 8 bytes of a
// block), then offers the digest as four 64-bit transactions, most significant
// first, and starts over. The input is stalled from the last transaction until
// the fourth digest word is taken.
module sha256_message_digest (
  input  logic               clk,
  input  logic               rst,
  input  logic               msg_valid,
  output logic               msg_stall,
  input  sha256_pkg::msg_t   msg,
  output logic               dig_valid,
  input  logic               dig_stall,
  output sha256_pkg::dig_t   dig
);

`include "sha256_message_digest_defines.svh"

  sha256_pkg::state_t state;
  sha256_pkg::state_t state_next;

  logic [511:0]      line;
  sha256_pkg::vars_t vars;
  sha256_pkg::vars_t vars_next;
  sha256_pkg::vars_t hash;
  sha256_pkg::word_t w_next;
  logic [5:0]        fill;
  logic [63:0]       msg_len;
  logic [5:0]        round_count;
  logic [1:0]        word_index;
  logic              pad_active;
  logic              pad_first;
  logic              need_wrap;
  logic              final_blk;

  logic              byte_go;
  logic [7:0]        byte_val;
  logic [7:0]        pad_byte;
  logic [63:0]       len_bits;

  logic              blk_take;
  logic              dig_take;
  logic              msg_clear;
  logic              out_barred;

  sha256_round u_round (
    .vars      (vars),
    .k         (sha256_pkg::ROUND_K[round_count]),
    .w0        (line[511:480]),
    .w1        (line[479:448]),
    .w9        (line[223:192]),
    .w14       (line[63:32]),
    .vars_next (vars_next),
    .w_next    (w_next)
  );

  always_comb begin
    len_bits = {msg_len[60:0], 3'b000};
    if (pad_first) begin
      pad_byte = sha256_pkg::PAD_MARK;
    end else if (need_wrap || (fill[5:3] != 3'b111)) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = 8'(len_bits >> {~fill[2:0], 3'b000});
    end
  end

  always_comb begin
    state_next = state;
    byte_go    = 1'b0;
    byte_val   = msg.data_byte;
    msg_stall  = (state != sha256_pkg::S_IDLE);
    dig_valid  = (state == sha256_pkg::S_OUT);
    case (state)
      sha256_pkg::S_IDLE: begin
        if (msg_valid) begin
          byte_go = msg.byte_valid;
          if (msg.byte_valid && (fill == sha256_pkg::FILL_LAST)) begin
            state_next = sha256_pkg::S_ROUND;
          end else if (msg.last_byte) begin
            state_next = sha256_pkg::S_PAD;
          end
        end
      end
      sha256_pkg::S_PAD: begin
        byte_go  = 1'b1;
        byte_val = pad_byte;
        if (fill == sha256_pkg::FILL_LAST) begin
          state_next = sha256_pkg::S_ROUND;
        end
      end
      sha256_pkg::S_ROUND: begin
        if (round_count == sha256_pkg::ROUND_LAST) begin
          state_next = sha256_pkg::S_UPDATE;
        end
      end
      sha256_pkg::S_UPDATE: begin
        if (final_blk) begin
          state_next = sha256_pkg::S_OUT;
        end else if (pad_active) begin
          state_next = sha256_pkg::S_PAD;
        end else begin
          state_next = sha256_pkg::S_IDLE;
        end
      end
      sha256_pkg::S_OUT: begin
        if (!dig_stall && (word_index == sha256_pkg::WORD_LAST)) begin
          state_next = sha256_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sha256_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha256_pkg::S_IDLE;
      fill        <= '0;
      msg_len     <= '0;
      round_count <= '0;
      word_index  <= '0;
      pad_active  <= 1'b0;
      pad_first   <= 1'b0;
      need_wrap   <= 1'b0;
      final_blk   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha256_pkg::HASH_IV[i];
      end
    end else begin
      state <= state_next;
      if ((state == sha256_pkg::S_IDLE) && msg_valid && msg.last_byte) begin
        pad_active <= 1'b1;
        pad_first  <= 1'b1;
      end
      if (byte_go) begin
        fill <= fill + 6'd1;
        if (state == sha256_pkg::S_IDLE) begin
          msg_len <= msg_len + 64'd1;
        end
      end
      if (state == sha256_pkg::S_PAD) begin
        if (pad_first) begin
          pad_first <= 1'b0;
        end
        if (fill == sha256_pkg::FILL_LAST) begin
          need_wrap <= 1'b0;
          if (!pad_first && !need_wrap) begin
            final_blk <= 1'b1;
          end
        end else if (pad_first) begin
          need_wrap <= (fill[5:3] == 3'b111);
        end
      end
      if (state == sha256_pkg::S_ROUND) begin
        round_count <= round_count + 6'd1;
      end
      if (state == sha256_pkg::S_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
      if ((state == sha256_pkg::S_OUT) && !dig_stall) begin
        word_index <= word_index + 2'd1;
        if (word_index == sha256_pkg::WORD_LAST) begin
          msg_len    <= '0;
          pad_active <= 1'b0;
          final_blk  <= 1'b0;
          for (int i = 0; i < 8; i++) begin
            hash[i] <= sha256_pkg::HASH_IV[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_go) begin
      line <= {line[503:0], byte_val};
      if (fill == sha256_pkg::FILL_LAST) begin
        vars <= hash;
      end
    end else if (state == sha256_pkg::S_ROUND) begin
      line <= {line[479:0], w_next};
      vars <= vars_next;
    end
  end

  always_comb begin
    dig.digest_word = {hash[{word_index, 1'b0}], hash[{word_index, 1'b1}]};
    dig.word_index  = word_index;
    dig.final_word  = (word_index == sha256_pkg::WORD_LAST);
  end

  always_comb begin
    blk_take   = msg_valid && !msg_stall && msg.byte_valid && (fill == sha256_pkg::FILL_LAST);
    dig_take   = dig_valid && !dig_stall && dig.final_word;
    msg_clear  = (msg_len == 64'd0) && (fill == 6'd0) && !pad_active;
    out_barred = (state != sha256_pkg::S_OUT) && (state != sha256_pkg::S_UPDATE);
  end

  `SHA_ASSERT_IMPL(a_round_idle, state != sha256_pkg::S_ROUND, round_count == 6'd0)
  `SHA_ASSERT_NEXT(a_block_starts, blk_take, state == sha256_pkg::S_ROUND)
  `SHA_ASSERT_NEXT(a_digest_done, dig_take, (state == sha256_pkg::S_IDLE) && msg_clear)
  `SHA_ASSERT_NEXT(a_out_entry, out_barred, state != sha256_pkg::S_OUT)

endmodule

>>> bench/tb.sv
// Self-checking testbench for the SHA-256 byte-stream digest block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int DRAIN_CYCLES = 400;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  sha256_pkg::msg_t msg = '0;
  logic dig_valid;
  logic dig_stall = 1'b0;
  sha256_pkg::dig_t dig;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int message_items = 0;

  logic [31:0] chain_hash [8];
  logic [7:0]  block_bytes [64];
  int          block_fill;
  logic [63:0] byte_count;
  sha256_pkg::dig_t digest_queue [$];

  sha256_message_digest u_top (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void reset_digest_state();
    for (int i = 0; i < 8; i++) chain_hash[i] = START_HASH[i];
    for (int i = 0; i < 64; i++) block_bytes[i] = '0;
    block_fill = 0;
    byte_count = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [16];
    logic [31:0] v [8];
    logic [31:0] wr, w15, w2, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = sched[r];
      end else begin
        w15 = sched[(r + 1) & 15];
        w2 = sched[(r + 14) & 15];
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wr = sched[r & 15] + s0 + sched[(r + 9) & 15] + s1;
        sched[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_hash[i] = chain_hash[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_bytes[block_fill] = b;
    block_fill++;
    byte_count = byte_count + 64'd1;
    if (block_fill == 64) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  function automatic void close_message();
    logic [63:0] bit_len;
    sha256_pkg::dig_t d;
    bit_len = byte_count << 3;
    block_bytes[block_fill] = PAD_BYTE;
    block_fill++;
    if (block_fill > 56) begin
      for (int i = block_fill; i < 64; i++) block_bytes[i] = '0;
      compress_block();
      block_fill = 0;
    end
    for (int i = block_fill; i < 56; i++) block_bytes[i] = '0;
    for (int i = 0; i < 8; i++) block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int k = 0; k < 4; k++) begin
      d.digest_word = {chain_hash[2*k], chain_hash[2*k+1]};
      d.word_index = k[1:0];
      d.final_word = (k == 3);
      digest_queue.push_back(d);
    end
    reset_digest_state();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_digest
    sha256_pkg::dig_t want;
    if (!rst && dig_valid && !dig_stall) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected digest transaction", dig.digest_word, '0);
      end else begin
        want = digest_queue.pop_front();
        if (dig.digest_word !== want.digest_word)
          report_mismatch("digest_word", dig.digest_word, want.digest_word);
        if (dig.word_index !== want.word_index)
          report_mismatch("word_index", dig.word_index, want.word_index);
        if (dig.final_word !== want.final_word)
          report_mismatch("final_word", dig.final_word, want.final_word);
      end
    end
  end

  always @(posedge clk) begin
    dig_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(input logic [7:0] b, input logic has_byte, input logic is_last);
    sha256_pkg::msg_t item;
    item.data_byte = b;
    item.byte_valid = has_byte;
    item.last_byte = is_last;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg <= item;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    if (has_byte) absorb_byte(b);
    if (is_last) close_message();
    if (has_byte || is_last) message_items++;
  endtask

  task automatic send_message(input int len, input bit separate_last);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !separate_last);
    end
    if (len == 0 || separate_last) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic wait_for_digests();
    msg_valid <= 1'b0;
    do @(posedge clk); while (digest_queue.size() != 0);
  endtask

  function automatic int pick_length();
    int edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    case ($urandom_range(7))
      0: return edges[$urandom_range(9)];
      1: return $urandom_range(40);
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic test_empty_message();
    send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic test_abc_message();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  task automatic test_extreme_bytes();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_idle_and_bare_last();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  task automatic test_restart_after_drain();
    wait_for_digests();
    send_message($urandom_range(1, 8), 1'b0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int quota);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = message_items + quota;
    while (message_items < target) send_message(pick_length(), $urandom_range(3) == 0);
  endtask

  initial begin
    reset_digest_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_abc_message();
    test_extreme_bytes();
    test_idle_and_bare_last();
    test_random_phase(0, 0, 100);
    test_restart_after_drain();
    test_random_phase(54, 0, 100);
    test_random_phase(0, 54, 100);
    test_random_phase(34, 34, 100);
    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/sha256_pkg.sv
sv/sha256_round.sv
sv/sha256_message_digest.sv
bench/tb.sv
